FILE: rtl/core/swm_pkg.sv
// Package: widths, deque entry type, sequencer states, pointer and window helpers.
`timescale 1ns / 1ps
`default_nettype none
package swm_pkg;

    localparam int WINDOW_MAX = 64;
    localparam int SAMPLE_W   = 16;
    localparam int POS_W      = 16;
    localparam int WIN_CFG_W  = 7;
    localparam int PTR_W      = $clog2(WINDOW_MAX);
    localparam int CNT_W      = $clog2(WINDOW_MAX + 1);

    typedef struct packed {
        logic [POS_W-1:0]           pos;
        logic signed [SAMPLE_W-1:0] val;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef enum logic [1:0] {
        S_IDLE,
        S_FRONT,
        S_REAR,
        S_PUSH
    } t_state;

    function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] s);
        return (s == PTR_W'(WINDOW_MAX - 1)) ? '0 : s + PTR_W'(1);
    endfunction

    function automatic logic [PTR_W-1:0] ptr_prev(input logic [PTR_W-1:0] s);
        return (s == '0) ? PTR_W'(WINDOW_MAX - 1) : s - PTR_W'(1);
    endfunction

    // zero acts as one, anything above the deque depth saturates
    function automatic logic [CNT_W-1:0] eff_window(input logic [WIN_CFG_W-1:0] cfg);
        int unsigned v;
        v = 32'(cfg);
        if (v == 0) begin
            v = 1;
        end
        if (v > WINDOW_MAX) begin
            v = WINDOW_MAX;
        end
        return CNT_W'(v);
    endfunction

endpackage
`default_nettype wire

FILE: rtl/core/swm_if.sv
// Interfaces: sample input channel and maximum output channel.
`timescale 1ns / 1ps
`default_nettype none
interface swm_in_if
    import swm_pkg::*;
;
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       first_of_array;

    modport source (output valid, output sample, output first_of_array, input ready);
    modport sink   (input valid, input sample, input first_of_array, output ready);
endinterface

interface swm_out_if
    import swm_pkg::*;
;
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] maximum;

    modport source (output valid, output maximum, input ready);
    modport sink   (input valid, input maximum, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/swm_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module swm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

FILE: rtl/core/sliding_window_maximum.sv
// Top level: sliding window maximum over a monotonic deque held in RAM.
//
// Channels: i_in carries one signed sample and a first_of_array mark per
// transaction; o_out carries the window maximum. Both use valid/ready.
// i_cfg_we/i_cfg_wdata write window_size (0 acts as 1, above 64 saturates);
// write it only while the block is idle.
// After acceptance the front state drops expired front entries, the front
// and rear states drop rear entries no larger than the sample, and the push
// state writes the sample at the rear; each drop is a read-compare on a
// deque RAM port. No new sample is taken before the push, and the next one
// is taken the cycle after the push. Each entry is dropped at most once, so
// drops average at most one per sample. The result is shown on o_out the
// cycle after the push.
// The deque lives in two mirrored RAMs (front and rear read ports) with a
// registered read; a just-written entry is forwarded on a read of the same
// slot.
// Reset empties the deque, restarts the sequence and sets window_size to 1.
// A result sits in an output register; a new sample is taken while it waits,
// but the push of a sample with a result waits until that register is free.
`timescale 1ns / 1ps
`default_nettype none
module sliding_window_maximum
    import swm_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    swm_in_if.sink                    i_in,
    swm_out_if.source                 o_out,
    input  wire logic                 i_cfg_we,
    input  wire logic [WIN_CFG_W-1:0] i_cfg_wdata
);
    t_state r_state, n_state;

    logic [WIN_CFG_W-1:0]       r_win_size;
    logic [CNT_W-1:0]           r_win, n_win;
    logic signed [SAMPLE_W-1:0] r_x, n_x;
    logic [POS_W-1:0]           r_p, n_p;
    logic [POS_W-1:0]           r_pos, n_pos;
    logic [PTR_W-1:0]           r_head, n_head;
    logic [PTR_W-1:0]           r_tail, n_tail;
    logic [CNT_W-1:0]           r_count, n_count;
    logic [CNT_W-1:0]           r_seen, n_seen;

    logic                       r_out_valid;
    logic signed [SAMPLE_W-1:0] r_out_max;

    logic                       r_fwd_f, r_fwd_r;
    t_entry                     r_fwd_data;

    logic                       we;
    t_entry                     wdata;
    logic [PTR_W-1:0]           rd_f, rd_r;
    logic [ENTRY_W-1:0]         q_f, q_r;
    t_entry                     ent_f, ent_r;

    logic                       accept;
    logic                       pop_f, pop_r;
    logic [CNT_W-1:0]           seen_inc;
    logic                       need_out, out_free, proceed, load_out;
    logic signed [SAMPLE_W-1:0] max_val;

    // front and rear read ports as two mirrored copies
    swm_ram #(.WIDTH(ENTRY_W), .DEPTH(WINDOW_MAX)) u_ram_front (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_tail),
        .i_wdata (wdata),
        .i_raddr (rd_f),
        .o_rdata (q_f)
    );

    swm_ram #(.WIDTH(ENTRY_W), .DEPTH(WINDOW_MAX)) u_ram_rear (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_tail),
        .i_wdata (wdata),
        .i_raddr (rd_r),
        .o_rdata (q_r)
    );

    assign ent_f = r_fwd_f ? r_fwd_data : t_entry'(q_f);
    assign ent_r = r_fwd_r ? r_fwd_data : t_entry'(q_r);

    assign accept   = (r_state == S_IDLE) && i_in.valid;
    assign pop_f    = (r_count != '0) && ((r_p - ent_f.pos) >= POS_W'(r_win));
    assign pop_r    = (r_count != '0) && (ent_r.val <= r_x);
    assign seen_inc = (r_seen < CNT_W'(WINDOW_MAX)) ? r_seen + CNT_W'(1) : r_seen;
    assign need_out = (seen_inc >= r_win);
    assign out_free = !r_out_valid || o_out.ready;
    assign proceed  = !need_out || out_free;
    // an empty deque before the push means the new sample is the front
    assign max_val  = (r_count == '0) ? r_x : ent_f.val;
    assign load_out = (r_state == S_PUSH) && need_out && out_free;

    assign i_in.ready    = (r_state == S_IDLE);
    assign o_out.valid   = r_out_valid;
    assign o_out.maximum = r_out_max;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_state = S_FRONT;
                end
            end
            S_FRONT: begin
                priority if (pop_f) begin
                    n_state = S_FRONT;
                end else if (pop_r) begin
                    n_state = S_REAR;
                end else begin
                    n_state = S_PUSH;
                end
            end
            S_REAR: begin
                n_state = pop_r ? S_REAR : S_PUSH;
            end
            S_PUSH: begin
                n_state = proceed ? S_IDLE : S_PUSH;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_win   = r_win;
        n_x     = r_x;
        n_p     = r_p;
        n_pos   = r_pos;
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        n_seen  = r_seen;
        we      = 1'b0;
        wdata   = '{pos: r_p, val: r_x};
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_win = eff_window(r_win_size);
                    n_x   = i_in.sample;
                    if (i_in.first_of_array) begin
                        n_head  = '0;
                        n_tail  = '0;
                        n_count = '0;
                        n_seen  = '0;
                        n_p     = '0;
                    end else begin
                        n_p = r_pos;
                    end
                end
            end
            S_FRONT: begin
                priority if (pop_f) begin
                    n_head  = ptr_next(r_head);
                    n_count = r_count - CNT_W'(1);
                end else if (pop_r) begin
                    n_tail  = ptr_prev(r_tail);
                    n_count = r_count - CNT_W'(1);
                end else begin
                    n_count = r_count;
                end
            end
            S_REAR: begin
                if (pop_r) begin
                    n_tail  = ptr_prev(r_tail);
                    n_count = r_count - CNT_W'(1);
                end
            end
            S_PUSH: begin
                if (proceed) begin
                    if (r_count < CNT_W'(WINDOW_MAX)) begin
                        we      = 1'b1;
                        n_tail  = ptr_next(r_tail);
                        n_count = r_count + CNT_W'(1);
                    end
                    n_pos  = r_p + POS_W'(1);
                    n_seen = seen_inc;
                end
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    // read the slots the pointers will hold next cycle
    assign rd_f = n_head;
    assign rd_r = ptr_prev(n_tail);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_win_size  <= WIN_CFG_W'(1);
            r_win       <= CNT_W'(1);
            r_pos       <= '0;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_seen      <= '0;
            r_out_valid <= 1'b0;
            r_fwd_f     <= 1'b0;
            r_fwd_r     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_win_size <= i_cfg_wdata;
            end
            r_win   <= n_win;
            r_pos   <= n_pos;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
            r_seen  <= n_seen;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            r_fwd_f <= we && (rd_f == r_tail);
            r_fwd_r <= we && (rd_r == r_tail);
        end
    end

    always_ff @(posedge i_clk) begin
        r_x <= n_x;
        r_p <= n_p;
        if (load_out) begin
            r_out_max <= max_val;
        end
        if (we) begin
            r_fwd_data <= wdata;
        end
    end
endmodule
`default_nettype wire

FILE: rtl/core/swm_checker.sv
// Port-level checker for the sliding window maximum, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module swm_checker
    import swm_pkg::*;
(
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_in_valid,
    input wire logic                i_in_ready,
    input wire logic                i_out_valid,
    input wire logic                i_out_ready,
    input wire logic [SAMPLE_W-1:0] i_out_maximum
);
    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_maximum)))
        else $error("stalled result changed or dropped");

    a_reset_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !i_out_valid)
        else $error("result shown right after reset");

    // one sample in flight: no back-to-back transactions
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input taken while a sample is in work");

    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(!(i_in_valid && i_in_ready)))
        else $error("result appeared on the cycle after an input transaction");
endmodule

bind sliding_window_maximum swm_checker u_swm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_maximum (o_out.maximum)
);
`default_nettype wire
